FILE: hw/rtl/gbs_pkg.sv
// gbs_pkg: shared constants and types for the greedy box suppression core
// no dependencies; used by gbs_front, gbs_back and greedy_box_suppression_core
package gbs_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int CNT_W         = 7;   // holds a box count up to 64
    localparam int COORD_W       = 16;
    localparam int SCORE_W       = 16;
    localparam int LABEL_W       = 8;
    localparam int THR_W         = 9;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_MODE  = 2'd1;

    localparam logic [THR_W-1:0] THR_RESET = 9'd128;

    localparam logic MODE_UNION   = 1'b0;
    localparam logic MODE_SMALLER = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             dropped;
    } t_cmd;

endpackage

FILE: hw/rtl/gbs_ram.sv
// gbs_ram: generic single write, single read ram with registered read data
// no dependencies
module gbs_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/gbs_front.sv
// gbs_front: accepts box beats, writes them to the box stores, closes a set
// depends on gbs_pkg; hands a set command to gbs_back through a one-entry queue
module gbs_front #(
    parameter int MaxBoxes = gbs_pkg::MAX_BOXES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_last_box,
    output logic                                 o_we,
    output logic [$clog2(MaxBoxes)-1:0]          o_waddr,
    output logic                                 o_cmd_valid,
    output gbs_pkg::t_cmd                        o_cmd,
    input  logic                                 i_cmd_pop,
    input  logic                                 i_set_done
);

    localparam int AW = $clog2(MaxBoxes);

    logic [gbs_pkg::CNT_W-1:0] r_count;
    logic                      r_dropped;
    logic                      r_hold;
    logic                      r_cmd_valid;
    gbs_pkg::t_cmd             r_cmd;
    logic                      w_accept;
    logic                      w_room;
    logic [gbs_pkg::CNT_W-1:0] n_count;
    logic                      n_dropped;

    assign o_ready  = !r_hold;
    assign w_accept = i_valid && !r_hold;
    assign w_room   = r_count < gbs_pkg::CNT_W'(MaxBoxes);
    assign o_we     = w_accept && w_room;
    assign o_waddr  = r_count[AW-1:0];

    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        if (w_room) begin
            n_count = r_count + 1'b1;
        end else begin
            n_dropped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_hold      <= 1'b0;
            r_cmd_valid <= 1'b0;
        end else begin
            if (i_cmd_pop) begin
                r_cmd_valid <= 1'b0;
            end
            if (i_set_done) begin
                r_hold <= 1'b0;
            end
            if (w_accept) begin
                if (i_last_box) begin
                    r_cmd_valid   <= 1'b1;
                    r_cmd.count   <= n_count;
                    r_cmd.dropped <= n_dropped;
                    r_hold        <= 1'b1;
                    r_count       <= '0;
                    r_dropped     <= 1'b0;
                end else begin
                    r_count   <= n_count;
                    r_dropped <= n_dropped;
                end
            end
        end
    end

    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;

endmodule

FILE: hw/rtl/gbs_back.sv
// gbs_back: pick scan, overlap suppression pipeline and result register
// depends on gbs_pkg; reads the box stores, takes set commands from gbs_front
module gbs_back #(
    parameter int MaxBoxes = gbs_pkg::MAX_BOXES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_valid,
    input  gbs_pkg::t_cmd                        i_cmd,
    output logic                                 o_cmd_pop,
    output logic                                 o_set_done,
    input  logic [gbs_pkg::THR_W-1:0]            i_thr,
    input  logic                                 i_mode,
    output logic [$clog2(MaxBoxes)-1:0]          o_raddr,
    input  logic [4*gbs_pkg::COORD_W-1:0]        i_coord,
    input  logic [gbs_pkg::SCORE_W+gbs_pkg::LABEL_W-1:0] i_sl,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [gbs_pkg::COORD_W-1:0]   o_x1,
    output logic signed [gbs_pkg::COORD_W-1:0]   o_y1,
    output logic signed [gbs_pkg::COORD_W-1:0]   o_x2,
    output logic signed [gbs_pkg::COORD_W-1:0]   o_y2,
    output logic [gbs_pkg::SCORE_W-1:0]          o_score,
    output logic [gbs_pkg::LABEL_W-1:0]          o_label,
    output logic                                 o_last,
    output logic                                 o_overflow
);

    localparam int AW = $clog2(MaxBoxes);
    localparam int CW = gbs_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_PICK, S_LOAD, S_AREA, S_SUPP, S_EMIT
    } t_state;

    t_state r_state;

    logic [MaxBoxes-1:0] r_live;
    logic [CW-1:0]       r_cnt;
    logic                r_dropped;
    logic [CW-1:0]       r_iss;
    logic                r_found;
    logic [AW-1:0]       r_best;
    logic [gbs_pkg::SCORE_W-1:0] r_best_score;

    logic signed [15:0] r_px1, r_py1, r_px2, r_py2;
    logic [gbs_pkg::SCORE_W-1:0] r_pscore;
    logic [gbs_pkg::LABEL_W-1:0] r_plabel;
    logic signed [33:0] r_parea;

    // pipeline stage valids and indexes
    logic          r_va, r_vb, r_vc, r_vd;
    logic [AW-1:0] r_ia, r_ib, r_ic, r_id;

    logic [16:0]        r_iw, r_ih;
    logic signed [16:0] r_dx, r_dy;
    logic [33:0]        r_inter_b;
    logic signed [33:0] r_area_b;
    logic [33:0]        r_inter_c;
    logic signed [35:0] r_den;

    logic r_ovalid;
    logic signed [15:0] r_ox1, r_oy1, r_ox2, r_oy2;
    logic [gbs_pkg::SCORE_W-1:0] r_oscore;
    logic [gbs_pkg::LABEL_W-1:0] r_olabel;
    logic r_olast, r_oovf;

    logic signed [15:0] w_jx1, w_jy1, w_jx2, w_jy2;
    logic signed [15:0] w_lx, w_ty, w_rx, w_by;
    logic signed [17:0] w_iw, w_ih;
    logic [gbs_pkg::SCORE_W-1:0] w_s;
    logic               w_issue;
    logic signed [35:0] w_inter_s, w_ap, w_aj;
    logic [44:0]        w_rhs, w_lhs;
    logic               w_kill;
    logic [MaxBoxes-1:0] w_init;
    logic               w_oslot;

    assign w_jx1 = signed'(i_coord[15:0]);
    assign w_jy1 = signed'(i_coord[31:16]);
    assign w_jx2 = signed'(i_coord[47:32]);
    assign w_jy2 = signed'(i_coord[63:48]);
    assign w_s   = i_sl[gbs_pkg::SCORE_W+gbs_pkg::LABEL_W-1:gbs_pkg::LABEL_W];

    assign w_lx = (w_jx1 > r_px1) ? w_jx1 : r_px1;
    assign w_ty = (w_jy1 > r_py1) ? w_jy1 : r_py1;
    assign w_rx = (w_jx2 < r_px2) ? w_jx2 : r_px2;
    assign w_by = (w_jy2 < r_py2) ? w_jy2 : r_py2;
    assign w_iw = 18'(w_rx) - 18'(w_lx) + 18'sd1;
    assign w_ih = 18'(w_by) - 18'(w_ty) + 18'sd1;

    assign w_issue = r_iss < r_cnt;
    assign o_raddr = (r_state == S_PICK) ? r_best : r_iss[AW-1:0];

    assign w_inter_s = signed'(36'(r_inter_b));
    assign w_ap      = 36'(r_parea);
    assign w_aj      = 36'(r_area_b);

    assign w_lhs = 45'({r_inter_c, 8'd0});
    assign w_rhs = 45'(r_den[34:0]) * 45'(i_thr);

    always_comb begin
        if (r_den > 36'sd0) begin
            w_kill = w_lhs > w_rhs;
        end else if (r_den == 36'sd0) begin
            w_kill = r_inter_c != '0;
        end else begin
            w_kill = 1'b0;
        end
    end

    always_comb begin
        for (int k = 0; k < MaxBoxes; k++) begin
            w_init[k] = CW'(k) < i_cmd.count;
        end
    end

    assign w_oslot    = !r_ovalid || i_ready;
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_set_done = ((r_state == S_IDLE) && i_cmd_valid && (w_init == '0)) ||
                        ((r_state == S_EMIT) && w_oslot && (r_live == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_live   <= '0;
            r_va     <= 1'b0;
            r_vb     <= 1'b0;
            r_vc     <= 1'b0;
            r_vd     <= 1'b0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_live    <= w_init;
                        r_cnt     <= i_cmd.count;
                        r_dropped <= i_cmd.dropped;
                        r_iss     <= '0;
                        r_found   <= 1'b0;
                        r_va      <= 1'b0;
                        if (w_init != '0) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_va && r_live[r_ia] && (!r_found || w_s >= r_best_score)) begin
                        r_best       <= r_ia;
                        r_best_score <= w_s;
                        r_found      <= 1'b1;
                    end
                    r_va <= w_issue;
                    r_ia <= r_iss[AW-1:0];
                    if (w_issue) begin
                        r_iss <= r_iss + 1'b1;
                    end else if (!r_va) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_live[r_best] <= 1'b0;
                    r_state        <= S_LOAD;
                end
                S_LOAD: begin
                    r_px1    <= w_jx1;
                    r_py1    <= w_jy1;
                    r_px2    <= w_jx2;
                    r_py2    <= w_jy2;
                    r_pscore <= w_s;
                    r_plabel <= i_sl[gbs_pkg::LABEL_W-1:0];
                    r_state  <= S_AREA;
                end
                S_AREA: begin
                    r_parea <= (17'(r_px2) - 17'(r_px1)) * (17'(r_py2) - 17'(r_py1));
                    r_iss   <= '0;
                    r_va    <= 1'b0;
                    r_vb    <= 1'b0;
                    r_vc    <= 1'b0;
                    r_vd    <= 1'b0;
                    r_state <= S_SUPP;
                end
                S_SUPP: begin
                    r_va <= w_issue;
                    r_ia <= r_iss[AW-1:0];
                    if (w_issue) begin
                        r_iss <= r_iss + 1'b1;
                    end
                    // stage a: edges of the intersection, sides of box j
                    r_vb <= r_va;
                    r_ib <= r_ia;
                    r_iw <= w_iw[17] ? '0 : w_iw[16:0];
                    r_ih <= w_ih[17] ? '0 : w_ih[16:0];
                    r_dx <= 17'(w_jx2) - 17'(w_jx1);
                    r_dy <= 17'(w_jy2) - 17'(w_jy1);
                    // stage b: products
                    r_vc      <= r_vb;
                    r_ic      <= r_ib;
                    r_inter_b <= r_iw * r_ih;
                    r_area_b  <= r_dx * r_dy;
                    // stage c: denominator
                    r_vd      <= r_vc;
                    r_id      <= r_ic;
                    r_inter_c <= r_inter_b;
                    if (i_mode == gbs_pkg::MODE_UNION) begin
                        r_den <= w_ap + w_aj - w_inter_s;
                    end else begin
                        r_den <= (w_ap < w_aj) ? w_ap : w_aj;
                    end
                    // stage d: threshold compare
                    if (r_vd && w_kill) begin
                        r_live[r_id] <= 1'b0;
                    end
                    if (!w_issue && !r_va && !r_vb && !r_vc && !r_vd) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_oslot) begin
                        r_ovalid <= 1'b1;
                        r_ox1    <= r_px1;
                        r_oy1    <= r_py1;
                        r_ox2    <= r_px2;
                        r_oy2    <= r_py2;
                        r_oscore <= r_pscore;
                        r_olabel <= r_plabel;
                        r_olast  <= r_live == '0;
                        r_oovf   <= r_dropped;
                        r_iss    <= '0;
                        r_found  <= 1'b0;
                        r_va     <= 1'b0;
                        r_state  <= (r_live == '0) ? S_IDLE : S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_x1       = r_ox1;
    assign o_y1       = r_oy1;
    assign o_x2       = r_ox2;
    assign o_y2       = r_oy2;
    assign o_score    = r_oscore;
    assign o_label    = r_olabel;
    assign o_last     = r_olast;
    assign o_overflow = r_oovf;

endmodule

FILE: hw/rtl/greedy_box_suppression_core.sv
// greedy_box_suppression_core: top level of the box suppression block
// depends on gbs_pkg, gbs_ram, gbs_front, gbs_back
//
// usage:
//   input channel (i_valid/o_ready) takes one box per beat; a beat with
//   i_last_box closes the set. boxes beyond MAX_BOXES are dropped and the
//   set's results carry o_overflow. output channel (o_valid/i_ready) gives
//   one kept box per beat in pick order; o_last_kept marks the final one of
//   the set. config channel (i_cfg_valid/o_cfg_ready, always ready) writes
//   the iou threshold (index 0) and overlap mode (index 1); the user must do
//   so only while the block is idle, as the block itself does not enforce it.
// timing:
//   the back end takes a set in the cycle after its closing beat; then each
//   pick makes one score scan and one pass through the four stage overlap
//   pipeline, each reading the box store one entry a cycle. o_ready stays low
//   from the closing beat until the last result of the set is in the output
//   register.
// reset: synchronous active low; the block comes up empty with threshold 128
//   and union mode. a stalled receiver holds the result register and stops
//   the back end; nothing is lost.
module greedy_box_suppression_core #(
    parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [gbs_pkg::COORD_W-1:0]  i_box_x1,
    input  logic signed [gbs_pkg::COORD_W-1:0]  i_box_y1,
    input  logic signed [gbs_pkg::COORD_W-1:0]  i_box_x2,
    input  logic signed [gbs_pkg::COORD_W-1:0]  i_box_y2,
    input  logic [gbs_pkg::SCORE_W-1:0]         i_score,
    input  logic [gbs_pkg::LABEL_W-1:0]         i_label,
    input  logic                                i_last_box,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [gbs_pkg::COORD_W-1:0]  o_kept_x1,
    output logic signed [gbs_pkg::COORD_W-1:0]  o_kept_y1,
    output logic signed [gbs_pkg::COORD_W-1:0]  o_kept_x2,
    output logic signed [gbs_pkg::COORD_W-1:0]  o_kept_y2,
    output logic [gbs_pkg::SCORE_W-1:0]         o_kept_score,
    output logic [gbs_pkg::LABEL_W-1:0]         o_kept_label,
    output logic                                o_last_kept,
    output logic                                o_overflow,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gbs_pkg::THR_W-1:0]           i_cfg_data
);

    localparam int AW  = $clog2(MAX_BOXES);
    localparam int SLW = gbs_pkg::SCORE_W + gbs_pkg::LABEL_W;

    logic [gbs_pkg::THR_W-1:0] r_thr;
    logic                      r_mode;

    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [AW-1:0]             w_raddr;
    logic [4*gbs_pkg::COORD_W-1:0] w_coord;
    logic [SLW-1:0]            w_sl;
    logic                      w_cmd_valid;
    gbs_pkg::t_cmd             w_cmd;
    logic                      w_cmd_pop;
    logic                      w_set_done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= gbs_pkg::THR_RESET;
            r_mode <= gbs_pkg::MODE_UNION;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gbs_pkg::CFG_IOU_THRESHOLD: r_thr  <= i_cfg_data;
                gbs_pkg::CFG_OVERLAP_MODE:  r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    gbs_front #(.MaxBoxes(MAX_BOXES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_last_box  (i_last_box),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop),
        .i_set_done  (w_set_done)
    );

    gbs_ram #(.Width(4*gbs_pkg::COORD_W), .Depth(MAX_BOXES)) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_box_y2, i_box_x2, i_box_y1, i_box_x1}),
        .i_raddr (w_raddr),
        .o_rdata (w_coord)
    );

    gbs_ram #(.Width(SLW), .Depth(MAX_BOXES)) u_sl_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_score, i_label}),
        .i_raddr (w_raddr),
        .o_rdata (w_sl)
    );

    gbs_back #(.MaxBoxes(MAX_BOXES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_set_done  (w_set_done),
        .i_thr       (r_thr),
        .i_mode      (r_mode),
        .o_raddr     (w_raddr),
        .i_coord     (w_coord),
        .i_sl        (w_sl),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_x1        (o_kept_x1),
        .o_y1        (o_kept_y1),
        .o_x2        (o_kept_x2),
        .o_y2        (o_kept_y2),
        .o_score     (o_kept_score),
        .o_label     (o_kept_label),
        .o_last      (o_last_kept),
        .o_overflow  (o_overflow)
    );

endmodule

FILE: dv/tb_greedy_box_suppression_core.sv
// tb_greedy_box_suppression_core: self-checking bench for the box suppression core
// drives box sets and config writes, predicts the kept boxes in-bench and checks every beat
// depends on gbs_pkg and greedy_box_suppression_core
`timescale 1ns / 1ps

module tb_greedy_box_suppression_core;
    import gbs_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] x1, y1, x2, y2;
        logic [SCORE_W-1:0]        score;
        logic [LABEL_W-1:0]        label;
        logic                      last;
    } box_t;

    typedef struct {
        box_t b;
        logic overflow;
    } kept_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [COORD_W-1:0] i_box_x1 = '0, i_box_y1 = '0, i_box_x2 = '0, i_box_y2 = '0;
    logic [SCORE_W-1:0] i_score = '0;
    logic [LABEL_W-1:0] i_label = '0;
    logic i_last_box = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [COORD_W-1:0] o_kept_x1, o_kept_y1, o_kept_x2, o_kept_y2;
    logic [SCORE_W-1:0] o_kept_score;
    logic [LABEL_W-1:0] o_kept_label;
    logic o_last_kept, o_overflow;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [THR_W-1:0] i_cfg_data = '0;

    greedy_box_suppression_core i_dut (.*);

    always #10 i_clk = ~i_clk;

    box_t  box_q[$];
    kept_t kept_q[$];
    int    errors = 0;
    bit    calm = 1'b0;
    int    send_gap = 0, recv_gap = 0;

    // in-bench copy of the block state
    box_t        set_box[MAX_BOXES_DEF];
    int          set_count = 0;
    bit          set_dropped = 1'b0;
    logic [THR_W-1:0] thr_reg = THR_RESET;
    logic        mode_reg = MODE_UNION;

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic longint area_of(box_t b);
        return (longint'(b.x2) - b.x1) * (longint'(b.y2) - b.y1);
    endfunction

    function automatic bit overlaps(box_t a, box_t p);
        longint lx, ty, rx, by, iw, ih, inter, aa, ab, den;
        lx = a.x1 > p.x1 ? a.x1 : p.x1;
        ty = a.y1 > p.y1 ? a.y1 : p.y1;
        rx = a.x2 < p.x2 ? a.x2 : p.x2;
        by = a.y2 < p.y2 ? a.y2 : p.y2;
        iw = rx - lx + 1;
        ih = by - ty + 1;
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter = iw * ih;
        aa = area_of(a);
        ab = area_of(p);
        den = (mode_reg == MODE_UNION) ? aa + ab - inter : (aa < ab ? aa : ab);
        if (den > 0) return inter * 256 > longint'(thr_reg) * den;
        if (den == 0) return inter > 0;
        return 1'b0;
    endfunction

    function automatic void suppress_set();
        bit    live[MAX_BOXES_DEF];
        int    best, nlive;
        kept_t k;
        nlive = set_count;
        for (int i = 0; i < MAX_BOXES_DEF; i++) live[i] = (i < set_count);
        while (nlive > 0) begin
            best = -1;
            for (int i = 0; i < set_count; i++)
                if (live[i] && (best < 0 || set_box[i].score >= set_box[best].score)) best = i;
            live[best] = 1'b0;
            nlive--;
            for (int j = 0; j < set_count; j++)
                if (live[j] && overlaps(set_box[j], set_box[best])) begin
                    live[j] = 1'b0;
                    nlive--;
                end
            k.b = set_box[best];
            k.b.last = (nlive == 0);
            k.overflow = set_dropped;
            kept_q.insert(kept_q.size(), k);
        end
        set_count = 0;
        set_dropped = 1'b0;
    endfunction

    function automatic void take_box(box_t b);
        if (set_count < MAX_BOXES_DEF) begin
            set_box[set_count] = b;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (b.last) suppress_set();
    endfunction

    // input driver
    always @(posedge i_clk) begin
        box_t b;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                take_box('{i_box_x1, i_box_y1, i_box_x2, i_box_y2, i_score, i_label, i_last_box});
            if (i_valid && !o_ready) begin
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (box_q.size() > 0 && !calm && $urandom_range(0, 4) == 0) begin
                send_gap <= $urandom_range(1, 6) - 1;
                i_valid <= 1'b0;
            end else if (box_q.size() > 0) begin
                b = box_q.pop_front();
                i_box_x1 <= b.x1;
                i_box_y1 <= b.y1;
                i_box_x2 <= b.x2;
                i_box_y2 <= b.y2;
                i_score <= b.score;
                i_label <= b.label;
                i_last_box <= b.last;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        kept_t k;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (kept_q.size() == 0) begin
                    report("extra result beat", 1, 0);
                end else begin
                    k = kept_q.pop_front();
                    if (o_kept_x1 !== k.b.x1) report("kept_x1", o_kept_x1, k.b.x1);
                    if (o_kept_y1 !== k.b.y1) report("kept_y1", o_kept_y1, k.b.y1);
                    if (o_kept_x2 !== k.b.x2) report("kept_x2", o_kept_x2, k.b.x2);
                    if (o_kept_y2 !== k.b.y2) report("kept_y2", o_kept_y2, k.b.y2);
                    if (o_kept_score !== k.b.score) report("kept_score", o_kept_score, k.b.score);
                    if (o_kept_label !== k.b.label) report("kept_label", o_kept_label, k.b.label);
                    if (o_last_kept !== k.b.last) report("last_kept", o_last_kept, k.b.last);
                    if (o_overflow !== k.overflow) report("overflow", o_overflow, k.overflow);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(1, 6) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic box_t make_box(int kind, int cx, int cy);
        box_t b;
        int w, h;
        w = $urandom_range(1, 400);
        h = $urandom_range(1, 400);
        case (kind)
            0: begin
                b.x1 = 16'(cx + int'($urandom_range(0, 80)) - 40);
                b.y1 = 16'(cy + int'($urandom_range(0, 80)) - 40);
                b.x2 = 16'(b.x1 + w);
                b.y2 = 16'(b.y1 + h);
            end
            1: begin
                b.x1 = 16'($urandom);
                b.y1 = 16'($urandom);
                b.x2 = 16'($urandom);
                b.y2 = 16'($urandom);
            end
            2: begin
                b.x1 = 16'(cx + w);
                b.y1 = 16'(cy);
                b.x2 = 16'(cx);
                b.y2 = 16'(cy + h);
            end
            default: begin
                b.x1 = 16'(cx);
                b.y1 = 16'(cy);
                b.x2 = 16'(cx + ($urandom_range(0, 1) ? w : 0));
                b.y2 = 16'(cy);
            end
        endcase
        b.score = $urandom_range(0, 3) == 0 ? 16'(100 * $urandom_range(0, 3)) : 16'($urandom);
        b.label = 8'($urandom);
        b.last = 1'b0;
        return b;
    endfunction

    task automatic push_set(int n);
        box_t b;
        int cx, cy, kind;
        cx = $urandom_range(0, 2000) - 1000;
        cy = $urandom_range(0, 2000) - 1000;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            b = make_box(kind < 6 ? 0 : kind < 8 ? 1 : kind == 8 ? 2 : 3, cx, cy);
            b.last = (i == n - 1);
            box_q.insert(box_q.size(), b);
        end
    endtask

    // sampled after the clock edge so driven valid and predictions are settled
    task automatic wait_idle();
        do @(negedge i_clk); while (box_q.size() > 0 || i_valid || kept_q.size() > 0);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_IOU_THRESHOLD) thr_reg = data;
        else mode_reg = data[0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_box(int x1, int y1, int x2, int y2, int s, int l, bit last);
        box_q.insert(box_q.size(), '{16'(x1), 16'(y1), 16'(x2), 16'(y2), 16'(s), 8'(l), last});
    endtask

    initial begin
        int sent, n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single box, equal-score ties, extremes, inverted, zero area
        push_box(0, 0, 16, 16, 65535, 255, 1'b1);
        push_box(10, 10, 50, 50, 500, 1, 1'b0);
        push_box(10, 10, 50, 50, 500, 2, 1'b0);
        push_box(12, 12, 52, 52, 500, 3, 1'b0);
        push_box(-32768, -32768, 32767, 32767, 0, 4, 1'b0);
        push_box(32767, 32767, -32768, -32768, 65535, 5, 1'b0);
        push_box(5, 5, 5, 5, 65535, 6, 1'b0);
        push_box(5, 5, 5, 5, 1, 7, 1'b0);
        push_box(900, 900, 950, 950, 2, 0, 1'b1);
        wait_idle();
        write_cfg(CFG_IOU_THRESHOLD, 9'd0);
        write_cfg(CFG_OVERLAP_MODE, MODE_SMALLER);
        push_box(0, 0, 100, 100, 7, 8, 1'b0);
        push_box(99, 99, 300, 300, 9, 9, 1'b0);
        push_box(0, 0, 10, 10, 9, 10, 1'b0);
        push_box(-40, -40, -20, -20, 3, 11, 1'b1);
        wait_idle();
        write_cfg(CFG_IOU_THRESHOLD, 9'd256);
        push_box(0, 0, 10, 10, 7, 12, 1'b0);
        push_box(0, 0, 10, 10, 8, 13, 1'b0);
        push_box(0, 0, 9, 9, 8, 14, 1'b1);
        wait_idle();
        write_cfg(CFG_IOU_THRESHOLD, 9'd511);
        write_cfg(CFG_OVERLAP_MODE, MODE_UNION);
        push_set(5);
        wait_idle();

        // capacity: one set drops boxes, one drops the closing box itself
        write_cfg(CFG_IOU_THRESHOLD, 9'd128);
        push_set(67);
        wait_idle();
        push_set(MAX_BOXES_DEF + 1);
        wait_idle();

        sent = 0;
        while (sent < 215) begin
            write_cfg(CFG_IOU_THRESHOLD, $urandom_range(0, 3) == 0 ? 9'($urandom) :
                      9'($urandom_range(0, 256)));
            write_cfg(CFG_OVERLAP_MODE, $urandom_range(0, 1) ? MODE_SMALLER : MODE_UNION);
            if (sent > 180) calm = 1'b1;
            for (int s = 0; s < 3; s++) begin
                n = $urandom_range(0, 15) == 0 ? $urandom_range(20, 66) : $urandom_range(1, 10);
                push_set(n);
                sent += n;
            end
            wait_idle();
        end

        if (errors == 0)
            $display("[greedy_box_suppression_core] OK");
        else
            $display("[greedy_box_suppression_core] ERROR");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("[greedy_box_suppression_core] ERROR");
        $finish;
    end

endmodule

FILE: greedy_box_suppression_core.f
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_ram.sv
hw/rtl/gbs_front.sv
hw/rtl/gbs_back.sv
hw/rtl/greedy_box_suppression_core.sv
dv/tb_greedy_box_suppression_core.sv
